@@ rtl/skh_pkg.sv @@
// skh_pkg: types, constants and helpers shared by the sorted key-sum histogram
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package skh_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 16;
  localparam int SUM_W       = 48;
  localparam int WEIGHT_W    = 32;
  localparam int FKEY_W      = 16;
  localparam int INDEX_W     = 6;
  localparam int ENTRIES_W   = 7;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic SEL_BW = 1'b0;
  localparam logic SEL_TS = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [FKEY_W-1:0]     bandwidth;
    logic [FKEY_W-1:0]     timescale;
    logic [WEIGHT_W-1:0]   weight;
    logic                  table_select;
    logic [INDEX_W-1:0]    entry_index;
  } in_t;

  typedef struct packed {
    logic [FKEY_W-1:0]     entry_key;
    logic [SUM_W-1:0]      entry_sum;
    logic                  entry_valid;
    logic [ENTRIES_W-1:0]  bandwidth_entries;
    logic [ENTRIES_W-1:0]  timescale_entries;
    logic [SUM_W-1:0]      total_weight;
    logic [FKEY_W-1:0]     max_bandwidth;
    logic [FKEY_W-1:0]     max_timescale;
    logic [WEIGHT_W-1:0]   max_weight;
    logic [1:0]            dropped;
  } out_t;

  typedef struct packed {
    logic start;
    logic is_read;
  } tbl_cmd_t;

  typedef struct packed {
    logic done;
    logic dropped;
    logic rd_valid;
  } tbl_stat_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/sorted_key_sum_histogram_top.sv @@
// sorted key-sum histogram: one bandwidth table, one timescale table, totals
// and maxima; depends on skh_pkg and skh_table
//
// usage:
//   in channel (in_valid/in_ready/in_data) carries one add or read item a beat.
//   out channel (out_valid/out_ready/out_data) returns exactly one result per item.
//   an add searches each table from its top entry down, reading then checking
//   each entry; a new key then takes a decision step, a read and a write per
//   entry moved up, and a final write; an add into an empty table only writes.
//   both tables work in parallel.
//   a read waits for the memory, then loads the result; an index past the count skips the memory.
//   throughput is one item at a time, bounded by the memory walk of the tables.
//   the result sits in an output register until taken; no new beat is accepted
//   while it waits or while a table is busy.
//   reset clears entry counts, totals and maxima; table memories need no clearing
//   since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_sum_histogram_top #(
  parameter int TABLE_DEPTH = skh_pkg::TABLE_DEPTH,
  parameter int KEY_WIDTH   = skh_pkg::KEY_WIDTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire skh_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output skh_pkg::out_t     out_data
);
  import skh_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {T_IDLE, T_BUSY} tstate_t;

  tstate_t           state;
  logic              accept;
  tbl_cmd_t          bw_cmd, ts_cmd;
  tbl_stat_t         bw_stat, ts_stat;
  logic [KEY_WIDTH-1:0] bw_rkey, ts_rkey;
  logic [SUM_W-1:0]  bw_rsum, ts_rsum;
  logic [CW-1:0]     bw_cnt, ts_cnt;
  logic              bw_done, ts_done;
  logic              op, sel;
  logic [SUM_W-1:0]  weight_total;
  logic [FKEY_W-1:0] bw_max, ts_max;
  logic [WEIGHT_W-1:0] weight_max;
  logic              bw_fin, ts_fin;

  assign in_ready = (state == T_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  assign bw_cmd.start   = accept && (in_data.op == OP_ADD || in_data.table_select == SEL_BW);
  assign bw_cmd.is_read = in_data.op;
  assign ts_cmd.start   = accept && (in_data.op == OP_ADD || in_data.table_select == SEL_TS);
  assign ts_cmd.is_read = in_data.op;

  skh_table #(.DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_bw (
    .clk, .rst, .cmd(bw_cmd), .key(KEY_WIDTH'(in_data.bandwidth)),
    .weight(in_data.weight), .index(in_data.entry_index), .stat(bw_stat),
    .rd_key(bw_rkey), .rd_sum(bw_rsum), .count(bw_cnt)
  );

  skh_table #(.DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_ts (
    .clk, .rst, .cmd(ts_cmd), .key(KEY_WIDTH'(in_data.timescale)),
    .weight(in_data.weight), .index(in_data.entry_index), .stat(ts_stat),
    .rd_key(ts_rkey), .rd_sum(ts_rsum), .count(ts_cnt)
  );

  assign bw_fin = bw_done || bw_stat.done;
  assign ts_fin = ts_done || ts_stat.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      out_valid    <= 1'b0;
      bw_done      <= 1'b0;
      ts_done      <= 1'b0;
      weight_total <= '0;
      bw_max       <= '0;
      ts_max       <= '0;
      weight_max   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            op      <= in_data.op;
            sel     <= in_data.table_select;
            // a read only runs the selected table
            bw_done <= !bw_cmd.start;
            ts_done <= !ts_cmd.start;
            state   <= T_BUSY;
            if (in_data.op == OP_ADD) begin
              weight_total <= sat_add(weight_total, in_data.weight);
              if (in_data.bandwidth > bw_max) bw_max <= in_data.bandwidth;
              if (in_data.timescale > ts_max) ts_max <= in_data.timescale;
              if (in_data.weight > weight_max) weight_max <= in_data.weight;
            end
          end
        end
        T_BUSY: begin
          if (bw_stat.done) bw_done <= 1'b1;
          if (ts_stat.done) ts_done <= 1'b1;
          if (bw_fin && ts_fin) begin
            out_valid                  <= 1'b1;
            out_data.bandwidth_entries <= ENTRIES_W'(bw_cnt);
            out_data.timescale_entries <= ENTRIES_W'(ts_cnt);
            out_data.total_weight      <= weight_total;
            out_data.max_bandwidth     <= bw_max;
            out_data.max_timescale     <= ts_max;
            out_data.max_weight        <= weight_max;
            if (op == OP_ADD) begin
              out_data.entry_key   <= '0;
              out_data.entry_sum   <= '0;
              out_data.entry_valid <= 1'b0;
              out_data.dropped     <= {ts_stat.dropped, bw_stat.dropped};
            end else begin
              out_data.dropped <= 2'b00;
              if (sel == SEL_TS) begin
                out_data.entry_key   <= FKEY_W'(ts_rkey);
                out_data.entry_sum   <= ts_rsum;
                out_data.entry_valid <= ts_stat.rd_valid;
              end else begin
                out_data.entry_key   <= FKEY_W'(bw_rkey);
                out_data.entry_sum   <= bw_rsum;
                out_data.entry_valid <= bw_stat.rd_valid;
              end
            end
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/skh_table.sv @@
// skh_table: one sorted key/sum table held in a synchronous memory
// scans top-down for the key, then shifts entries up to insert; uses skh_pkg
`timescale 1ns / 1ps
`default_nettype none

module skh_table #(
  parameter int DEPTH     = skh_pkg::TABLE_DEPTH,
  parameter int KEY_WIDTH = skh_pkg::KEY_WIDTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire skh_pkg::tbl_cmd_t             cmd,
  input  wire logic [KEY_WIDTH-1:0]          key,
  input  wire logic [skh_pkg::WEIGHT_W-1:0]  weight,
  input  wire logic [skh_pkg::INDEX_W-1:0]   index,
  output skh_pkg::tbl_stat_t                 stat,
  output logic [KEY_WIDTH-1:0]               rd_key,
  output logic [skh_pkg::SUM_W-1:0]          rd_sum,
  output logic [CW-1:0]                      count
);
  import skh_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW   = KEY_WIDTH + SUM_W;
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHK, S_DEC, S_SHRD, S_SHWR, S_INS, S_RWAIT, S_RD
  } state_t;

  state_t          state;
  logic [AW-1:0]   ptr;
  logic [AW-1:0]   pos;
  logic [EW-1:0]   mem [DEPTH];
  logic [EW-1:0]   rdata;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [EW-1:0]   wdata;
  logic [KEY_WIDTH-1:0] rk;
  logic [SUM_W-1:0]     rs;
  logic [KEY_WIDTH-1:0] key_q;
  logic [WEIGHT_W-1:0]  weight_q;

  assign rk = rdata[EW-1:SUM_W];
  assign rs = rdata[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[ptr];
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = rdata;
    case (state)
      S_CHK: begin
        if (rk == key_q) begin
          we    = 1'b1;
          wdata = {rk, sat_add(rs, weight_q)};
        end
      end
      S_SHWR: begin
        we    = 1'b1;
        waddr = ptr + AW'(1);
      end
      S_INS: begin
        we    = 1'b1;
        waddr = pos;
        wdata = {key_q, SUM_W'(weight_q)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      stat  <= '0;
    end else begin
      stat.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            stat.dropped <= 1'b0;
            key_q        <= key;
            weight_q     <= weight;
            if (cmd.is_read) begin
              if (CMPW'(index) < CMPW'(count)) begin
                ptr   <= AW'(index);
                state <= S_RWAIT;
              end else begin
                stat.rd_valid <= 1'b0;
                stat.done     <= 1'b1;
                rd_key        <= '0;
                rd_sum        <= '0;
              end
            end else if (count == '0) begin
              pos   <= '0;
              state <= S_INS;
            end else begin
              ptr   <= AW'(count - CW'(1));
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: state <= S_CHK;
        S_CHK: begin
          if (rk == key_q) begin
            stat.done <= 1'b1;
            state     <= S_IDLE;
          end else if (rk < key_q) begin
            pos   <= ptr + AW'(1);
            state <= S_DEC;
          end else if (ptr == '0) begin
            pos   <= '0;
            state <= S_DEC;
          end else begin
            ptr   <= ptr - AW'(1);
            state <= S_SCAN;
          end
        end
        S_DEC: begin
          if (count == CW'(DEPTH)) begin
            stat.dropped <= 1'b1;
            stat.done    <= 1'b1;
            state        <= S_IDLE;
          end else if (CW'(pos) == count) begin
            state <= S_INS;
          end else begin
            ptr   <= AW'(count - CW'(1));
            state <= S_SHRD;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          if (ptr == pos) begin
            state <= S_INS;
          end else begin
            ptr   <= ptr - AW'(1);
            state <= S_SHRD;
          end
        end
        S_INS: begin
          count     <= count + CW'(1);
          stat.done <= 1'b1;
          state     <= S_IDLE;
        end
        S_RWAIT: state <= S_RD;
        S_RD: begin
          // registered read data for ptr shows up in the cycle after ptr is set
          rd_key        <= rk;
          rd_sum        <= rs;
          stat.rd_valid <= 1'b1;
          stat.done     <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
